[rtl/isort_pkg.sv]
// ----------------------------------------------------------------------------
// isort_pkg
// Shared types for the insertion sorter: controller states and the command
// and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package isort_pkg;

  localparam int unsigned ValueW = 32;

  typedef enum logic [0:0] {
    ST_FILL,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic insert;     // take the request into the sorted row
    logic emit_load;  // move the lowest entry into the output register
  } cmd_t;

  typedef struct packed {
    logic out_busy;   // output register holds a result not yet taken
    logic one_left;   // exactly one entry remains in the row
  } sts_t;

endpackage

`default_nettype wire

[rtl/insertion_sorter.sv]
// ----------------------------------------------------------------------------
// insertion_sorter
// Streaming insertion sort of signed 32-bit values; a set closes on tlast
// and is then sent out in ascending order.
// ----------------------------------------------------------------------------
//  channel  dir  tdata              tuser      tlast
//  s_axis   in   [31:0] value       -          last_in
//  m_axis   out  [31:0] sorted_val  [0] ovf    last_out
//
//  While the set fills, one value per cycle is compared and shifted into the
//  register row. After the closing request s_axis_tready stays low while the
//  row unloads one entry per cycle as m_axis accepts them; the first result
//  is valid after the state register and then the output register update.
//  m_axis stalls hold the row and stretch the input stall to match.
//  Reset clears the count, the drop flag and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module insertion_sorter #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] value
  input  wire logic        s_axis_tlast,   // last_in
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [31:0] m_axis_tdata,   // [31:0] sorted_value
  output      logic        m_axis_tlast,   // last_out
  output      logic [0:0]  m_axis_tuser    // [0] overflow
);

  isort_pkg::cmd_t                     cmd;
  isort_pkg::sts_t                     sts;
  logic signed [isort_pkg::ValueW-1:0] out_value;
  logic                                out_ovf;

  isort_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .in_ready_o  (s_axis_tready),
    .cmd_o       (cmd)
  );

  isort_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .value_i     ($signed(s_axis_tdata)),
    .out_ready_i (m_axis_tready),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_value_o (out_value),
    .out_last_o  (m_axis_tlast),
    .out_ovf_o   (out_ovf)
  );

  assign m_axis_tdata    = out_value;
  assign m_axis_tuser[0] = out_ovf;

endmodule

`default_nettype wire

[rtl/isort_ctrl.sv]
// ----------------------------------------------------------------------------
// isort_ctrl
// Controller: collects a set, then unloads the sorted row one entry at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module isort_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            in_last_i,
  input  wire logic            out_ready_i,
  input  wire isort_pkg::sts_t sts_i,
  output      logic            in_ready_o,
  output      isort_pkg::cmd_t cmd_o
);

  isort_pkg::state_e state_q, state_d;
  logic              load;

  assign load = !sts_i.out_busy || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      isort_pkg::ST_FILL: begin
        if (in_valid_i && in_last_i) begin
          state_d = isort_pkg::ST_EMIT;
        end
      end
      isort_pkg::ST_EMIT: begin
        if (load && sts_i.one_left) begin
          state_d = isort_pkg::ST_FILL;
        end
      end
      default: state_d = isort_pkg::ST_FILL;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o.insert     = 1'b0;
    cmd_o.emit_load  = 1'b0;
    case (state_q)
      isort_pkg::ST_FILL: begin
        in_ready_o   = 1'b1;
        cmd_o.insert = in_valid_i;
      end
      isort_pkg::ST_EMIT: begin
        cmd_o.emit_load = load;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= isort_pkg::ST_FILL;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[rtl/isort_dp.sv]
// ----------------------------------------------------------------------------
// isort_dp
// Datapath: compare-and-shift register row, entry count, drop flag and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module isort_dp #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire isort_pkg::cmd_t                     cmd_i,
  input  wire logic signed [isort_pkg::ValueW-1:0] value_i,
  input  wire logic                                out_ready_i,
  output      isort_pkg::sts_t                     sts_o,
  output      logic                                out_valid_o,
  output      logic signed [isort_pkg::ValueW-1:0] out_value_o,
  output      logic                                out_last_o,
  output      logic                                out_ovf_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic signed [isort_pkg::ValueW-1:0] row_q [CAPACITY];
  logic signed [isort_pkg::ValueW-1:0] row_d [CAPACITY];
  logic        [CAPACITY-1:0]          gt;
  logic        [CntW-1:0]              cnt_q, cnt_d;
  logic                                drop_q, drop_d;
  logic                                full;
  logic                                vld_q, vld_d;

  assign full = (cnt_q == CntW'(CAPACITY));

  // An entry is greater when it is held and compares above the request;
  // held entries are sorted, so gt is a thermometer code.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      gt[i] = (CntW'(i) < cnt_q) && (row_q[i] > value_i);
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      row_d[i] = row_q[i];
    end
    if (cmd_i.insert && !full) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
          row_d[i] = row_q[(i > 0) ? i - 1 : 0];
        end else if (gt[i] || (CntW'(i) == cnt_q)) begin
          row_d[i] = value_i;
        end
      end
    end else if (cmd_i.emit_load) begin
      // advance the row down by one place
      for (int i = 0; i < CAPACITY - 1; i++) begin
        row_d[i] = row_q[i + 1];
      end
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    drop_d = drop_q;
    vld_d  = vld_q;
    if (out_ready_i) begin
      vld_d = 1'b0;
    end
    if (cmd_i.insert) begin
      if (full) begin
        drop_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CntW'(1);
      end
    end else if (cmd_i.emit_load) begin
      vld_d = 1'b1;
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        drop_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      drop_q <= 1'b0;
      vld_q  <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      drop_q <= drop_d;
      vld_q  <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      row_q[i] <= row_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_value_o <= row_q[0];
      out_last_o  <= (cnt_q == CntW'(1));
      out_ovf_o   <= drop_q;
    end
  end

  assign out_valid_o    = vld_q;
  assign sts_o.out_busy = vld_q;
  assign sts_o.one_left = (cnt_q == CntW'(1));

endmodule

`default_nettype wire

[verif/isort_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isort_checker
// Watches both stream channels of the insertion sorter. Every accepted
// request goes into a private sorted row, or marks the set as dropped if
// the row is full. A closing request turns the row into expected results,
// and each result taken from m_axis is compared with the oldest, by field.
// ----------------------------------------------------------------------------

module isort_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_tvalid_i,
  input  wire logic                        in_tready_i,
  input  wire logic [isort_pkg::ValueW-1:0] in_tdata_i,   // [31:0] value
  input  wire logic                        in_tlast_i,    // last_in
  input  wire logic                        out_tvalid_i,
  input  wire logic                        out_tready_i,
  input  wire logic [isort_pkg::ValueW-1:0] out_tdata_i,  // [31:0] sorted_value
  input  wire logic                        out_tlast_i,   // last_out
  input  wire logic [0:0]                  out_tuser_i,   // [0] overflow
  output      int                          mismatches_o,
  output      int                          pending_o
);

  typedef struct packed {
    logic signed [isort_pkg::ValueW-1:0] value;
    logic                                last;
    logic                                ovf;
  } sorted_result_t;

  logic signed [isort_pkg::ValueW-1:0] sorted_row[$];
  sorted_result_t                      pending_results[$];
  logic                                set_dropped = 1'b0;
  int                                  mismatch_count = 0;

  // Place the value after any equal entries; on close, unload the whole row.
  task automatic sort_insert(input logic signed [isort_pkg::ValueW-1:0] value,
                             input logic closes);
    int             pos;
    sorted_result_t res;
    pos = sorted_row.size();
    if (sorted_row.size() >= CAPACITY) begin
      set_dropped = 1'b1;
    end else begin
      for (int i = 0; i < sorted_row.size(); i++) begin
        if (sorted_row[i] > value) begin
          pos = i;
          break;
        end
      end
      sorted_row.insert(pos, value);
    end
    if (closes) begin
      for (int i = 0; i < sorted_row.size(); i++) begin
        res.value = sorted_row[i];
        res.last  = (i == sorted_row.size() - 1);
        res.ovf   = set_dropped;
        pending_results.push_back(res);
      end
      sorted_row.delete();
      set_dropped = 1'b0;
    end
  endtask

  task automatic compare_result();
    sorted_result_t want;
    if (pending_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: unexpected result value=%0d last=%0b ovf=%0b", $realtime,
                 $signed(out_tdata_i), out_tlast_i, out_tuser_i[0]);
    end else begin
      want = pending_results.pop_front();
      if (out_tdata_i !== want.value || out_tlast_i !== want.last ||
          out_tuser_i[0] !== want.ovf) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display({"%0t: mismatch exp value=%0d last=%0b ovf=%0b,",
                    " got value=%0d last=%0b ovf=%0b"},
                   $realtime, want.value, want.last, want.ovf,
                   $signed(out_tdata_i), out_tlast_i, out_tuser_i[0]);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sorted_row.delete();
      pending_results.delete();
      set_dropped = 1'b0;
    end else begin
      if (out_tvalid_i && out_tready_i) begin
        compare_result();
      end
      if (in_tvalid_i && in_tready_i) begin
        sort_insert(in_tdata_i, in_tlast_i);
      end
    end
    mismatches_o <= mismatch_count;
    pending_o    <= pending_results.size();
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench top for the insertion sorter. Sends sets of signed values: a
// directed part first (extremes, a one-value set, a set that overflows the
// row), then random sets of random length, with random gaps on both sides,
// a long back-pressure stretch and a full drain pause. The checker predicts
// and compares; this module gives the verdict.
// ----------------------------------------------------------------------------

module tb;

  localparam int unsigned Capacity = 16;
  localparam int unsigned RandomRequests = 350;

  logic        clk;
  logic        rst_n;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [0:0]  m_axis_tuser;

  int          mismatches;
  int          pending;

  logic        tx_idles;
  logic        rx_idles;
  logic        hold_req;

  insertion_sorter #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  isort_checker #(
    .CAPACITY(Capacity)
  ) checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_tvalid_i (s_axis_tvalid),
    .in_tready_i (s_axis_tready),
    .in_tdata_i  (s_axis_tdata),
    .in_tlast_i  (s_axis_tlast),
    .out_tvalid_i(m_axis_tvalid),
    .out_tready_i(m_axis_tready),
    .out_tdata_i (m_axis_tdata),
    .out_tlast_i (m_axis_tlast),
    .out_tuser_i (m_axis_tuser),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off each time hold_req toggles.
  initial begin : receiver
    int   hold_left;
    logic hold_seen;
    hold_left     = 0;
    hold_seen     = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 90;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (rx_idles) begin
        m_axis_tready <= ($urandom_range(99) >= 37);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic [31:0] value, input logic closes);
    while (tx_idles && $urandom_range(99) < 37) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= closes;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Mix of full-range values, a narrow band that yields duplicates, and extremes.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h8000_0000 + $urandom_range(2);
      1:       return 32'h7FFF_FFFF - $urandom_range(2);
      2, 3:    return 32'(int'($urandom_range(8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  // Let the checker count the last accepted request before polling.
  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [31:0] burst[$];
    int          sent;
    int          set_len;
    int          set_idx;
    rst_n         = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    tx_idles      = 1'b1;
    rx_idles      = 1'b1;
    hold_req      = 1'b0;
    sent          = 0;
    set_idx       = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Overflowing set: 16 held values, the closing request itself is dropped.
    burst = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
              32'h0000_0001, 32'h0000_0005, 32'h0000_0005, 32'hFFFF_FFFB,
              32'h7FFF_FFFE, 32'h8000_0001, 32'h0000_0003, 32'h0000_0003,
              32'h0000_0003, 32'h0000_0064, 32'hFFFF_FF9C, 32'h0F0F_0F0F,
              32'h0000_0007};
    foreach (burst[i]) send_request(burst[i], i == burst.size() - 1);
    // One-value set.
    send_request(32'hA5A5_5A5A, 1'b1);
    // Extremes in descending order.
    burst = '{32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000};
    foreach (burst[i]) send_request(burst[i], i == burst.size() - 1);

    while (sent < RandomRequests) begin
      set_len = ($urandom_range(9) == 0) ? $urandom_range(Capacity + 8, Capacity + 1)
                                         : $urandom_range(Capacity, 1);
      tx_idles = !(set_idx >= 8 && set_idx < 13);
      rx_idles = tx_idles;
      if (set_idx == 3) set_len = Capacity;
      for (int i = 0; i < set_len; i++) begin
        // Stall the output across the drain of a full set; the sender keeps going.
        if (set_idx == 3 && i == set_len - 1) hold_req <= ~hold_req;
        send_request(pick_value(), i == set_len - 1);
      end
      sent += set_len;
      if (set_idx == 6) begin
        s_axis_tvalid <= 1'b0;
        wait_drained();
      end
      set_idx++;
    end

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (Capacity + 8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
